// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the generator RTL.
// Each macro expands to one labelled concurrent assertion on the rising clock edge,
// switched off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every edge.
`define MTG_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
   else $error("mtg assertion failed");

// The consequence must hold in the cycle after the condition.
`define MTG_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
   else $error("mtg assertion failed");

`endif

// ----- rtl/core/mtg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtg_pkg
// Types, constants and the tempering and seeding functions of the MT19937
// generator.
// ----------------------------------------------------------------------------
package mtg_pkg;

   localparam int unsigned STATE_DEPTH   = 624;
   localparam int unsigned MIDDLE_OFFSET = 397;
   localparam int unsigned ADDR_W        = 10;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [31:0]       word_type;

   localparam addr_type LAST_ADDR   = addr_type'(STATE_DEPTH - 1);
   localparam addr_type SPENT_INDEX = addr_type'(STATE_DEPTH);
   localparam addr_type MID_ADDR    = addr_type'(MIDDLE_OFFSET);

   localparam word_type TWIST_XOR    = 32'h9908_b0df;
   localparam word_type TEMPER_B     = 32'h9d2c_5680;
   localparam word_type TEMPER_C     = 32'hefc6_0000;
   localparam word_type LCG_MUL      = 32'd69069;
   localparam word_type SEED_DEFAULT = 32'd4357;

   typedef enum logic {
      OP_DRAW = 1'b0,
      OP_LOAD = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_SEED,
      ST_IDLE,
      ST_PRIME,
      ST_TWIST
   } ctrl_state_type;

   typedef struct packed {
      logic     en;
      addr_type addr;
      word_type data;
   } mem_wr_type;

   function automatic word_type temper(input word_type w);
      word_type y;
      y = w;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

   function automatic word_type lcg_next(input word_type x);
      return word_type'(x * LCG_MUL) + 32'd1;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/mtg_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtg_req_if
// Request channel: one draw or load word per handshake.
// ----------------------------------------------------------------------------
interface mtg_req_if;
   logic                valid;
   logic                ready;
   mtg_pkg::opcode_type opcode;
   mtg_pkg::word_type   load_word;

   modport source (output valid, output opcode, output load_word, input ready);
   modport sink   (input valid, input opcode, input load_word, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/mtg_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtg_rsp_if
// Response channel: one tempered random word per handshake.
// ----------------------------------------------------------------------------
interface mtg_rsp_if;
   logic              valid;
   logic              ready;
   mtg_pkg::word_type random_word;

   modport source (output valid, output random_word, input ready);
   modport sink   (input valid, input random_word, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/mtg_state_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtg_state_ram
// State word memory: one write port and two registered read ports.
// ----------------------------------------------------------------------------
module mtg_state_ram (
   input  wire logic                clock,
   input  wire mtg_pkg::mem_wr_type wr,
   input  wire logic                rd_a_en,
   input  wire mtg_pkg::addr_type   rd_a_addr,
   output mtg_pkg::word_type        rd_a_data,
   input  wire logic                rd_b_en,
   input  wire mtg_pkg::addr_type   rd_b_addr,
   output mtg_pkg::word_type        rd_b_data
);

   mtg_pkg::word_type mem [mtg_pkg::STATE_DEPTH];
   mtg_pkg::word_type rd_a_ff;
   mtg_pkg::word_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Read data holds while the port is not enabled.
   always_ff @(posedge clock) begin
      if (rd_a_en) begin
         rd_a_ff <= mem[rd_a_addr];
      end
      if (rd_b_en) begin
         rd_b_ff <= mem[rd_b_addr];
      end
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule
`default_nettype wire

// ----- rtl/core/mtg_seed_gen.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtg_seed_gen
// Fills the state memory from a seed with the 69069 congruential rule, two
// steps of the recurrence per state word.
// ----------------------------------------------------------------------------
module mtg_seed_gen (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire mtg_pkg::word_type start_seed,
   output mtg_pkg::mem_wr_type    wr,
   output logic                   busy
);

   mtg_pkg::word_type x_ff,     x_in;
   logic [15:0]       hi_ff,    hi_in;
   mtg_pkg::addr_type idx_ff,   idx_in;
   logic              phase_ff, phase_in;
   logic              busy_ff,  busy_in;

   always_comb begin
      x_in     = x_ff;
      hi_in    = hi_ff;
      idx_in   = idx_ff;
      phase_in = phase_ff;
      busy_in  = busy_ff;
      wr       = '0;
      if (start) begin
         x_in     = start_seed;
         idx_in   = '0;
         phase_in = 1'b0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         x_in     = mtg_pkg::lcg_next(x_ff);
         phase_in = !phase_ff;
         if (!phase_ff) begin
            hi_in = x_ff[31:16];
         end else begin
            wr.en   = 1'b1;
            wr.addr = idx_ff;
            wr.data = {hi_ff, x_ff[31:16]};
            idx_in  = idx_ff + 1'b1;
            if (idx_ff == mtg_pkg::LAST_ADDR) begin
               busy_in = 1'b0;
            end
         end
      end
   end

   // Reset starts a fill from the default seed straight away.
   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff     <= mtg_pkg::SEED_DEFAULT;
         idx_ff   <= '0;
         phase_ff <= 1'b0;
         busy_ff  <= 1'b1;
      end else begin
         x_ff     <= x_in;
         idx_ff   <= idx_in;
         phase_ff <= phase_in;
         busy_ff  <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      hi_ff <= hi_in;
   end

   assign busy = busy_ff;

endmodule
`default_nettype wire

// ----- rtl/core/mersenne_twister_generator_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mersenne_twister_generator_core
// MT19937 random word generator with a 624-word state held in one memory.
// ----------------------------------------------------------------------------
// A draw word returns one tempered 32-bit word; a load word overwrites the
// next state word in order and returns nothing. Draws and loads are taken one
// per cycle as long as the response side keeps up. A draw that finds the
// state spent holds the request side while one read primes the pipeline and
// then one twist step runs per state word, as each step needs two memory
// reads and one write. After reset, and after every write to the seed
// register, the memory is filled from the seed (two steps of the congruential
// rule per word), and no word is taken until the fill has finished and the
// controller has left its seeding state.
module mersenne_twister_generator_core (
   input  wire logic              clock,
   input  wire logic              reset,
   mtg_req_if.sink                req_ch,
   mtg_rsp_if.source              rsp_ch,
   input  wire logic              csr_wr_en,
   input  wire mtg_pkg::word_type csr_wr_data
);

   `include "assert_macros.svh"

   mtg_pkg::ctrl_state_type state_ff, state_in;
   mtg_pkg::addr_type       ri_ff,    ri_in;
   mtg_pkg::addr_type       lp_ff,    lp_in;
   mtg_pkg::addr_type       twk_ff,   twk_in;
   logic                    pend_ff,  pend_in;
   logic                    hi_ff,    hi_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   mtg_pkg::word_type       rsp_word_ff,  rsp_word_in;

   mtg_pkg::mem_wr_type seed_wr;
   mtg_pkg::mem_wr_type mem_wr;
   logic                seed_busy;
   logic                rd_a_en, rd_b_en;
   mtg_pkg::addr_type   rd_a_addr, rd_b_addr;
   mtg_pkg::word_type   rd_a_data, rd_b_data;

   logic                out_free, can_take, accept, deliver, regen_need;
   mtg_pkg::addr_type   lp_eff, nxt_addr, mid_addr;
   logic [mtg_pkg::ADDR_W:0] mid_sum;
   mtg_pkg::word_type   twist_y;

   mtg_seed_gen u_seed_gen (
      .clock      (clock),
      .reset      (reset),
      .start      (csr_wr_en),
      .start_seed (csr_wr_data),
      .wr         (seed_wr),
      .busy       (seed_busy)
   );

   mtg_state_ram u_state_ram (
      .clock     (clock),
      .wr        (mem_wr),
      .rd_a_en   (rd_a_en),
      .rd_a_addr (rd_a_addr),
      .rd_a_data (rd_a_data),
      .rd_b_en   (rd_b_en),
      .rd_b_addr (rd_b_addr),
      .rd_b_data (rd_b_data)
   );

   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign deliver    = pend_ff && out_free;
   assign can_take   = (state_ff == mtg_pkg::ST_IDLE) && (!pend_ff || out_free);
   assign accept     = req_ch.valid && can_take;
   assign regen_need = ri_ff >= mtg_pkg::SPENT_INDEX;
   assign lp_eff     = (lp_ff >= mtg_pkg::SPENT_INDEX) ? '0 : lp_ff;

   // Addresses for the twist step after the one now being written.
   assign nxt_addr = (twk_ff == mtg_pkg::LAST_ADDR - 1'b1) ? '0 : twk_ff + 2'd2;
   assign mid_sum  = {1'b0, twk_ff} + {1'b0, mtg_pkg::MID_ADDR} + 1'b1;
   assign mid_addr = (mid_sum >= {1'b0, mtg_pkg::SPENT_INDEX})
                     ? mtg_pkg::addr_type'(mid_sum - {1'b0, mtg_pkg::SPENT_INDEX})
                     : mtg_pkg::addr_type'(mid_sum);

   assign twist_y = {hi_ff, rd_a_data[30:0]};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mtg_pkg::ST_SEED: begin
            if (!seed_busy) begin
               state_in = mtg_pkg::ST_IDLE;
            end
         end
         mtg_pkg::ST_IDLE: begin
            if (accept && req_ch.opcode == mtg_pkg::OP_DRAW && regen_need) begin
               state_in = mtg_pkg::ST_PRIME;
            end
         end
         mtg_pkg::ST_PRIME: begin
            state_in = mtg_pkg::ST_TWIST;
         end
         mtg_pkg::ST_TWIST: begin
            if (twk_ff == mtg_pkg::LAST_ADDR) begin
               state_in = mtg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mtg_pkg::ST_SEED;
         end
      endcase
      if (csr_wr_en) begin
         state_in = mtg_pkg::ST_SEED;
      end
   end

   always_comb begin
      ri_in        = ri_ff;
      lp_in        = lp_ff;
      twk_in       = twk_ff;
      pend_in      = pend_ff;
      hi_in        = hi_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      mem_wr       = '0;
      rd_a_en      = 1'b0;
      rd_a_addr    = '0;
      rd_b_en      = 1'b0;
      rd_b_addr    = '0;

      if (deliver) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = mtg_pkg::temper(rd_a_data);
         pend_in      = 1'b0;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         mtg_pkg::ST_SEED: begin
            mem_wr = seed_wr;
         end
         mtg_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_ch.opcode == mtg_pkg::OP_LOAD) begin
                  mem_wr.en   = 1'b1;
                  mem_wr.addr = lp_eff;
                  mem_wr.data = req_ch.load_word;
                  if (lp_eff == mtg_pkg::LAST_ADDR) begin
                     lp_in = '0;
                     ri_in = mtg_pkg::SPENT_INDEX;
                  end else begin
                     lp_in = lp_eff + 1'b1;
                  end
               end else if (regen_need) begin
                  // Fetch word zero so that its top bit is at hand for the first step.
                  rd_a_en   = 1'b1;
                  rd_a_addr = '0;
               end else begin
                  rd_a_en   = 1'b1;
                  rd_a_addr = ri_ff;
                  pend_in   = 1'b1;
                  ri_in     = ri_ff + 1'b1;
               end
            end
         end
         mtg_pkg::ST_PRIME: begin
            hi_in     = rd_a_data[31];
            rd_a_en   = 1'b1;
            rd_a_addr = mtg_pkg::addr_type'(1);
            rd_b_en   = 1'b1;
            rd_b_addr = mtg_pkg::MID_ADDR;
            twk_in    = '0;
         end
         mtg_pkg::ST_TWIST: begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = twk_ff;
            mem_wr.data = rd_b_data ^ (twist_y >> 1)
                          ^ (twist_y[0] ? mtg_pkg::TWIST_XOR : '0);
            hi_in       = rd_a_data[31];
            if (twk_ff == mtg_pkg::LAST_ADDR) begin
               // Last step: the draw that started the pass reads the fresh word zero.
               rd_a_en   = 1'b1;
               rd_a_addr = '0;
               pend_in   = 1'b1;
               ri_in     = mtg_pkg::addr_type'(1);
            end else begin
               rd_a_en   = 1'b1;
               rd_a_addr = nxt_addr;
               rd_b_en   = 1'b1;
               rd_b_addr = mid_addr;
               twk_in    = twk_ff + 1'b1;
            end
         end
         default: begin
            mem_wr = '0;
         end
      endcase

      if (csr_wr_en) begin
         ri_in = mtg_pkg::SPENT_INDEX;
         lp_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mtg_pkg::ST_SEED;
         ri_ff        <= mtg_pkg::SPENT_INDEX;
         lp_ff        <= '0;
         twk_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ri_ff        <= ri_in;
         lp_ff        <= lp_in;
         twk_ff       <= twk_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hi_ff       <= hi_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign req_ch.ready       = can_take;
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.random_word = rsp_word_ff;

   `MTG_ASSERT(a_seed_wr_only_seeding, clock, reset,
      !seed_wr.en || state_ff == mtg_pkg::ST_SEED)
   `MTG_ASSERT(a_pending_only_idle, clock, reset,
      !pend_ff || state_ff == mtg_pkg::ST_IDLE)
   `MTG_ASSERT(a_twist_index_in_range, clock, reset,
      state_ff != mtg_pkg::ST_TWIST || twk_ff <= mtg_pkg::LAST_ADDR)
   `MTG_ASSERT_NEXT(a_draw_sets_pending, clock, reset,
      accept && req_ch.opcode == mtg_pkg::OP_DRAW && !regen_need && !csr_wr_en,
      pend_ff)

endmodule
`default_nettype wire

// ----- test/mtg_draw_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtg_draw_checker
// Watches the request, response and seed ports of the generator, keeps its
// own copy of the 624-word twister state and checks every returned word.
// ----------------------------------------------------------------------------
module mtg_draw_checker (
   input  logic                 clock,
   input  logic                 reset,
   mtg_req_if                   req_mon,
   mtg_rsp_if                   rsp_mon,
   input  logic                 csr_wr_en,
   input  mtg_pkg::word_type    csr_wr_data,
   output int unsigned          fault_count,
   output int unsigned          outstanding,
   output int unsigned          words_checked,
   output int unsigned          refills,
   output int unsigned          full_loads
);

   localparam mtg_pkg::word_type TWIST_MASK = 32'h9908_b0df;
   localparam mtg_pkg::word_type MASK_B     = 32'h9d2c_5680;
   localparam mtg_pkg::word_type MASK_C     = 32'hefc6_0000;
   localparam mtg_pkg::word_type LCG_FACTOR = 32'd69069;
   localparam mtg_pkg::word_type RESET_SEED = 32'd4357;

   mtg_pkg::word_type state_mem [mtg_pkg::STATE_DEPTH];
   int unsigned       draw_pos;
   int unsigned       fill_pos;
   mtg_pkg::word_type awaited_words [$];

   initial begin
      fault_count   = 0;
      outstanding   = 0;
      words_checked = 0;
      refills       = 0;
      full_loads    = 0;
   end

   // Each state word takes the top halves of two successive congruential values.
   function automatic void seed_fill(input mtg_pkg::word_type s);
      mtg_pkg::word_type x;
      int unsigned       i;
      x = s;
      for (i = 0; i < mtg_pkg::STATE_DEPTH; i++) begin
         state_mem[i][31:16] = x[31:16];
         x = x * LCG_FACTOR + 32'd1;
         state_mem[i][15:0] = x[31:16];
         x = x * LCG_FACTOR + 32'd1;
      end
      draw_pos = mtg_pkg::STATE_DEPTH;
      fill_pos = 0;
   endfunction

   function automatic void twist_state();
      mtg_pkg::word_type y;
      mtg_pkg::word_type v;
      int unsigned       k;
      for (k = 0; k < mtg_pkg::STATE_DEPTH; k++) begin
         y = {state_mem[k][31], state_mem[(k + 1) % mtg_pkg::STATE_DEPTH][30:0]};
         v = state_mem[(k + mtg_pkg::MIDDLE_OFFSET) % mtg_pkg::STATE_DEPTH] ^ (y >> 1);
         if (y[0]) begin
            v = v ^ TWIST_MASK;
         end
         state_mem[k] = v;
      end
      draw_pos = 0;
      refills++;
   endfunction

   function automatic mtg_pkg::word_type tempered(input mtg_pkg::word_type w);
      mtg_pkg::word_type t;
      t = w ^ (w >> 11);
      t = t ^ ((t << 7) & MASK_B);
      t = t ^ ((t << 15) & MASK_C);
      return t ^ (t >> 18);
   endfunction

   function automatic void take_item(input mtg_pkg::opcode_type op,
                                     input mtg_pkg::word_type w);
      if (op == mtg_pkg::OP_LOAD) begin
         if (fill_pos >= mtg_pkg::STATE_DEPTH) begin
            fill_pos = 0;
         end
         state_mem[fill_pos] = w;
         fill_pos++;
         // The last word of a complete load leaves the state spent.
         if (fill_pos >= mtg_pkg::STATE_DEPTH) begin
            fill_pos = 0;
            draw_pos = mtg_pkg::STATE_DEPTH;
            full_loads++;
         end
      end else begin
         if (draw_pos >= mtg_pkg::STATE_DEPTH) begin
            twist_state();
         end
         awaited_words.push_back(tempered(state_mem[draw_pos]));
         draw_pos++;
      end
   endfunction

   function automatic void check_word(input mtg_pkg::word_type got);
      mtg_pkg::word_type want;
      if (awaited_words.size() == 0) begin
         $error("random_word unexpected: expected none, actual %h", got);
         fault_count++;
      end else begin
         want = awaited_words.pop_front();
         words_checked++;
         if (got !== want) begin
            $error("random_word mismatch: expected %h, actual %h", want, got);
            fault_count++;
         end
      end
   endfunction

   // The request is applied before the response is compared, so a word that
   // came back in the cycle of its own draw is still found in order.
   always @(posedge clock) begin
      if (reset) begin
         seed_fill(RESET_SEED);
      end else begin
         if (csr_wr_en) begin
            seed_fill(csr_wr_data);
         end
         if (req_mon.valid && req_mon.ready) begin
            take_item(req_mon.opcode, req_mon.load_word);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            check_word(rsp_mon.random_word);
         end
      end
      outstanding = awaited_words.size();
   end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives draw and load words into the generator under bursty request traffic
// and a stalling response side, across several seeds, with a checker beside it.
// ----------------------------------------------------------------------------
module testbench;

   localparam int unsigned CYCLE_LIMIT   = 400_000;
   localparam int unsigned SETTLE_CYCLES = 16;
   localparam int unsigned HOLD_CYCLES   = 400;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_wr_en = 1'b0;
   mtg_pkg::word_type csr_wr_data = '0;
   bit                hold_off_req = 1'b0;

   int unsigned fault_count;
   int unsigned outstanding;
   int unsigned words_checked;
   int unsigned refills;
   int unsigned full_loads;

   int unsigned cycle_count = 0;
   int unsigned burst_left = 0;
   int unsigned items_sent = 0;
   int unsigned loads_sent = 0;
   int unsigned loads_since_seed = 0;
   int unsigned seeds_written = 0;

   mtg_req_if req_ch ();
   mtg_rsp_if rsp_ch ();

   mersenne_twister_generator_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   mtg_draw_checker word_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .fault_count   (fault_count),
      .outstanding   (outstanding),
      .words_checked (words_checked),
      .refills       (refills),
      .full_loads    (full_loads)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("testbench: done, errors");
      $finish;
   end

   // Response side: runs of steady, random and mostly-stalled ready, plus one
   // long hold-off on request so that the generator backs up onto its input.
   initial begin
      int unsigned span;
      int unsigned mode;
      int unsigned k;
      rsp_ch.ready = 1'b0;
      forever begin
         if (hold_off_req) begin
            @(negedge clock);
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_off_req = 1'b0;
         end else begin
            span = $urandom_range(40, 4);
            mode = $urandom_range(2);
            for (k = 0; k < span; k++) begin
               @(negedge clock);
               case (mode)
                  0: rsp_ch.ready <= 1'b1;
                  1: rsp_ch.ready <= 1'($urandom_range(1));
                  default: rsp_ch.ready <= ($urandom_range(3) == 0);
               endcase
            end
         end
      end
   end

   function automatic mtg_pkg::word_type any_word();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return mtg_pkg::word_type'($urandom());
      endcase
   endfunction

   // Offers one word; a new burst opens with a random gap of idle cycles.
   task automatic offer(input mtg_pkg::opcode_type op, input mtg_pkg::word_type w);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(3) == 0) ? $urandom_range(80, 30) : $urandom_range(12, 1);
         gap = $urandom_range(6);
         if (gap > 0) begin
            @(negedge clock);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      @(negedge clock);
      req_ch.valid     <= 1'b1;
      req_ch.opcode    <= op;
      req_ch.load_word <= w;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      burst_left--;
      items_sent++;
      if (op == mtg_pkg::OP_LOAD) begin
         loads_sent++;
         loads_since_seed++;
      end
   endtask

   // Waits until every awaited word has come back and trailing loads are done.
   task automatic settle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_seed(input mtg_pkg::word_type s);
      settle();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= s;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      seeds_written++;
      loads_since_seed = 0;
   endtask

   initial begin
      int unsigned         phase_items;
      int unsigned         n;
      mtg_pkg::opcode_type op;
      req_ch.valid     = 1'b0;
      req_ch.opcode    = mtg_pkg::OP_DRAW;
      req_ch.load_word = '0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Default seed after reset: draws ignore the data, then a partial load, then draws again.
      offer(mtg_pkg::OP_DRAW, 32'h0000_0000);
      offer(mtg_pkg::OP_DRAW, 32'hffff_ffff);
      offer(mtg_pkg::OP_DRAW, 32'h1234_5678);
      offer(mtg_pkg::OP_LOAD, 32'h0000_0000);
      offer(mtg_pkg::OP_LOAD, 32'hffff_ffff);
      offer(mtg_pkg::OP_DRAW, 32'h0000_0000);
      offer(mtg_pkg::OP_DRAW, 32'hffff_ffff);

      // A seed write in the middle of a load restarts the load position.
      write_seed(32'h0000_0000);
      offer(mtg_pkg::OP_DRAW, 32'h0000_0000);
      offer(mtg_pkg::OP_DRAW, 32'h0000_0000);
      offer(mtg_pkg::OP_LOAD, 32'haaaa_aaaa);
      offer(mtg_pkg::OP_LOAD, 32'h5555_5555);
      offer(mtg_pkg::OP_DRAW, 32'hffff_ffff);

      write_seed(32'hffff_ffff);
      for (n = 0; n < 3; n++) begin
         offer(mtg_pkg::OP_DRAW, any_word());
      end

      // Mostly draws; the sender keeps offering for as long as the response
      // side is held off, so that the generator backs up onto its input.
      write_seed(mtg_pkg::word_type'($urandom()));
      phase_items = 0;
      while (phase_items < 70 || hold_off_req) begin
         op = ($urandom_range(99) < 85) ? mtg_pkg::OP_DRAW : mtg_pkg::OP_LOAD;
         offer(op, any_word());
         phase_items++;
         if (phase_items == 20) begin
            hold_off_req = 1'b1;
         end
      end

      // Mostly loads, carried on past the last state word so that a complete
      // load leaves the state spent; the draws after it force a refill.
      settle();
      while (loads_since_seed < 630) begin
         op = ($urandom_range(19) == 0) ? mtg_pkg::OP_DRAW : mtg_pkg::OP_LOAD;
         offer(op, any_word());
      end
      for (n = 0; n < 20; n++) begin
         offer(mtg_pkg::OP_DRAW, any_word());
      end

      write_seed(mtg_pkg::word_type'($urandom()));
      for (n = 0; n < 20; n++) begin
         op = ($urandom_range(1) == 0) ? mtg_pkg::OP_DRAW : mtg_pkg::OP_LOAD;
         offer(op, any_word());
      end

      settle();
      $display("run covered: %0d words offered, %0d of them loads, %0d seeds written",
               items_sent, loads_sent, seeds_written);
      $display("run covered: %0d random words compared, %0d refills, %0d complete loads",
               words_checked, refills, full_loads);
      if (fault_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/mtg_pkg.sv
rtl/core/mtg_req_if.sv
rtl/core/mtg_rsp_if.sv
rtl/core/mtg_state_ram.sv
rtl/core/mtg_seed_gen.sv
rtl/core/mersenne_twister_generator_core.sv
test/mtg_draw_checker.sv
test/testbench.sv
